FILE: hdl/hbc_pkg.sv
// ----------------------------------------------------------------------------
// Hall button calibration package
// Shared constants, codes and types of the Hall button calibration sequencer.
// ----------------------------------------------------------------------------
package hbc_pkg;

   localparam int BUTTONS = 8;
   localparam int BTN_W   = $clog2(BUTTONS);
   localparam int ADC_W   = 16;
   localparam int CNT_W   = 4;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 2;

   localparam logic [CNT_W-1:0] BUTTON_LIMIT = CNT_W'(BUTTONS);

   localparam logic [ADC_W-1:0] STABLE_TIME_RESET = 16'd250;
   localparam logic [ADC_W-1:0] PRESS_DELTA_RESET = 16'd250;
   localparam logic [ADC_W-1:0] ADC_MAX_RESET     = 16'd4095;
   localparam logic [ADC_W-1:0] ADC_MIN_RESET     = 16'd0;

   localparam logic [CSR_W-1:0] CSR_STABLE_TIME = 2'd0;
   localparam logic [CSR_W-1:0] CSR_PRESS_DELTA = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ADC_MAX     = 2'd2;
   localparam logic [CSR_W-1:0] CSR_ADC_MIN     = 2'd3;

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_CANCEL   = 2'd1,
      OP_SAMPLE   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_ENABLE  = 2'd1;
   localparam logic [1:0] MODE_DISABLE = 2'd2;

   localparam logic [2:0] STATE_IDLE            = 3'd0;
   localparam logic [2:0] STATE_WAIT_RELEASE    = 3'd1;
   localparam logic [2:0] STATE_CAPTURE_REST    = 3'd2;
   localparam logic [2:0] STATE_WAIT_PRESS      = 3'd3;
   localparam logic [2:0] STATE_CAPTURE_PRESSED = 3'd4;
   localparam logic [2:0] STATE_DONE            = 3'd5;

   typedef enum logic [5:0] {
      PH_IDLE            = 6'b000001,
      PH_WAIT_RELEASE    = 6'b000010,
      PH_CAPTURE_REST    = 6'b000100,
      PH_WAIT_PRESS      = 6'b001000,
      PH_CAPTURE_PRESSED = 6'b010000,
      PH_DONE            = 6'b100000
   } phase_type;

   typedef struct packed {
      logic             clear;
      logic             capture;
      logic             track;
      logic [BTN_W-1:0] btn;
      logic [ADC_W-1:0] sample;
   } store_cmd_type;

   typedef struct packed {
      logic             fire;
      logic [ADC_W-1:0] rest;
      logic [ADC_W-1:0] min;
      logic [ADC_W-1:0] max;
   } store_rsp_type;

   function automatic logic [2:0] phase_code(phase_type p);
      logic [2:0] code;
      case (p)
         PH_IDLE:            code = STATE_IDLE;
         PH_WAIT_RELEASE:    code = STATE_WAIT_RELEASE;
         PH_CAPTURE_REST:    code = STATE_CAPTURE_REST;
         PH_WAIT_PRESS:      code = STATE_WAIT_PRESS;
         PH_CAPTURE_PRESSED: code = STATE_CAPTURE_PRESSED;
         PH_DONE:            code = STATE_DONE;
         default:            code = STATE_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/hbc_store.sv
// ----------------------------------------------------------------------------
// Hall button calibration stores
// Per-button rest, minimum, maximum and done flags with the press detector.
// ----------------------------------------------------------------------------
module hbc_store (
   input  logic                        clock,
   input  logic                        reset,
   input  hbc_pkg::store_cmd_type      cmd,
   input  logic [hbc_pkg::ADC_W-1:0]   adc_max,
   input  logic [hbc_pkg::ADC_W-1:0]   adc_min,
   input  logic [hbc_pkg::ADC_W-1:0]   press_delta,
   output hbc_pkg::store_rsp_type      rsp
);
   import hbc_pkg::*;

   logic [ADC_W-1:0] rest_ff [BUTTONS];
   logic [ADC_W-1:0] min_ff  [BUTTONS];
   logic [ADC_W-1:0] max_ff  [BUTTONS];
   logic [BUTTONS-1:0] flag_ff;

   logic [ADC_W-1:0] rest;
   logic [ADC_W-1:0] lo;
   logic [ADC_W-1:0] hi;
   logic [ADC_W-1:0] distance;

   always_comb begin
      rest = rest_ff[cmd.btn];
      lo   = (cmd.sample < min_ff[cmd.btn]) ? cmd.sample : min_ff[cmd.btn];
      hi   = (cmd.sample > max_ff[cmd.btn]) ? cmd.sample : max_ff[cmd.btn];
      distance = (cmd.sample > rest) ? (cmd.sample - rest) : (rest - cmd.sample);
      rsp.fire = cmd.track && !flag_ff[cmd.btn] && (distance >= press_delta);
      rsp.rest = rest;
      rsp.min  = lo;
      rsp.max  = hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            rest_ff[i] <= '0;
            min_ff[i]  <= ADC_MAX_RESET;
            max_ff[i]  <= ADC_MIN_RESET;
         end
         flag_ff <= '0;
      end else if (cmd.clear) begin
         for (int i = 0; i < BUTTONS; i++) begin
            rest_ff[i] <= '0;
            min_ff[i]  <= adc_max;
            max_ff[i]  <= adc_min;
         end
         flag_ff <= '0;
      end else if (cmd.capture) begin
         rest_ff[cmd.btn] <= cmd.sample;
         min_ff[cmd.btn]  <= cmd.sample;
         max_ff[cmd.btn]  <= cmd.sample;
      end else if (cmd.track) begin
         min_ff[cmd.btn] <= lo;
         max_ff[cmd.btn] <= hi;
         if (rsp.fire) begin
            flag_ff[cmd.btn] <= 1'b1;
         end
      end
   end

endmodule

FILE: hdl/hall_button_calibration_fsm.sv
// ----------------------------------------------------------------------------
// Hall button calibration sequencer
// Steps a bank of Hall-effect buttons through rest capture and press
// detection and emits one calibration record per button.
// ----------------------------------------------------------------------------
// Commands and samples arrive on the req_ channel; every accepted transfer
// yields exactly one transfer on the rsp_ channel with the phase, the count
// of calibrated buttons, any calibration mode change and, when a button is
// first pressed far enough from rest, its calibration record.
// An item is held in an input register and then processed combinationally
// into the result register, so one item is taken every cycle while the
// result is not stalled. The per-button read, update and write back of the
// stores is the step that sets this rate. When rsp_stall is high the result
// holds; the input register still fills, and req_stall rises once both
// registers are occupied. Registers are written on the csr_ channel, always
// ready, while the block is idle; the user must keep to this, as the block
// does not enforce it. Synchronous reset restores register defaults, clears
// all per-button stores and empties both registers.
// ----------------------------------------------------------------------------
module hall_button_calibration_fsm (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [hbc_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [hbc_pkg::BTN_W-1:0]    req_button,
   input  logic [hbc_pkg::ADC_W-1:0]    req_adc_value,
   input  logic                         req_last_of_scan,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_fsm_state,
   output logic                         rsp_active,
   output logic [hbc_pkg::CNT_W-1:0]    rsp_done_count,
   output logic [1:0]                   rsp_mode_change,
   output logic                         rsp_record_valid,
   output logic [hbc_pkg::BTN_W-1:0]    rsp_record_button,
   output logic [hbc_pkg::ADC_W-1:0]    rsp_rest_value,
   output logic [hbc_pkg::ADC_W-1:0]    rsp_pressed_value,
   output logic [hbc_pkg::ADC_W-1:0]    rsp_min_value,
   output logic [hbc_pkg::ADC_W-1:0]    rsp_max_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hbc_pkg::CSR_W-1:0]    csr_index,
   input  logic [hbc_pkg::ADC_W-1:0]    csr_data
);
   import hbc_pkg::*;

   logic [ADC_W-1:0] stable_time_ff;
   logic [ADC_W-1:0] press_delta_ff;
   logic [ADC_W-1:0] adc_max_ff;
   logic [ADC_W-1:0] adc_min_ff;

   logic              in_valid_ff;
   logic [1:0]        op_ff;
   logic [TIME_W-1:0] now_ff;
   logic [BTN_W-1:0]  btn_ff;
   logic [ADC_W-1:0]  adc_ff;
   logic              last_ff;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [TIME_W-1:0] start_ff;
   logic [TIME_W-1:0] start_in;
   logic [CNT_W-1:0]  total_ff;
   logic [CNT_W-1:0]  total_in;

   logic              out_valid_ff;
   logic [2:0]        state_ff;
   logic              active_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [1:0]        mode_ff;
   logic              rec_ff;
   logic [BTN_W-1:0]  rec_btn_ff;
   logic [ADC_W-1:0]  rest_ff;
   logic [ADC_W-1:0]  pressed_ff;
   logic [ADC_W-1:0]  min_ff;
   logic [ADC_W-1:0]  max_ff;

   logic              advance;
   logic              in_range;
   logic [ADC_W-1:0]  sample;
   logic [TIME_W-1:0] elapsed;
   logic [1:0]        mode;
   store_cmd_type     store_cmd;
   store_rsp_type     store_rsp;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign sample   = (adc_ff > adc_max_ff) ? adc_max_ff : adc_ff;
   assign in_range = ({1'b0, btn_ff} < BUTTON_LIMIT);
   assign elapsed  = now_ff - start_ff;

   always_comb begin
      store_cmd         = '0;
      store_cmd.btn     = btn_ff;
      store_cmd.sample  = sample;
      phase_in          = phase_ff;
      start_in          = start_ff;
      total_in          = total_ff;
      mode              = MODE_NONE;
      case (op_type'(op_ff))
         OP_START: begin
            store_cmd.clear = advance;
            total_in        = '0;
            mode            = MODE_ENABLE;
            phase_in        = PH_WAIT_RELEASE;
            start_in        = now_ff;
         end
         OP_CANCEL: begin
            mode     = MODE_DISABLE;
            phase_in = PH_IDLE;
            start_in = now_ff;
         end
         OP_SAMPLE: begin
            store_cmd.capture = advance && in_range && (phase_ff == PH_CAPTURE_REST);
            store_cmd.track   = advance && in_range && (phase_ff == PH_WAIT_PRESS);
            if (store_rsp.fire) begin
               total_in = total_ff + CNT_W'(1);
            end
            if (last_ff) begin
               case (phase_ff)
                  PH_WAIT_RELEASE: begin
                     if (elapsed >= TIME_W'(stable_time_ff)) begin
                        phase_in = PH_CAPTURE_REST;
                        start_in = now_ff;
                     end
                  end
                  PH_CAPTURE_REST: begin
                     phase_in = PH_WAIT_PRESS;
                     start_in = now_ff;
                  end
                  PH_WAIT_PRESS: begin
                     if (total_in >= BUTTON_LIMIT) begin
                        phase_in = PH_CAPTURE_PRESSED;
                        start_in = now_ff;
                     end
                  end
                  PH_CAPTURE_PRESSED: begin
                     mode     = MODE_DISABLE;
                     phase_in = PH_DONE;
                     start_in = now_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   hbc_store u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (store_cmd),
      .adc_max     (adc_max_ff),
      .adc_min     (adc_min_ff),
      .press_delta (press_delta_ff),
      .rsp         (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_time_ff <= STABLE_TIME_RESET;
         press_delta_ff <= PRESS_DELTA_RESET;
         adc_max_ff     <= ADC_MAX_RESET;
         adc_min_ff     <= ADC_MIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STABLE_TIME: stable_time_ff <= csr_data;
            CSR_PRESS_DELTA: press_delta_ff <= csr_data;
            CSR_ADC_MAX:     adc_max_ff     <= csr_data;
            CSR_ADC_MIN:     adc_min_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff   <= req_operation;
         now_ff  <= req_now_ms;
         btn_ff  <= req_button;
         adc_ff  <= req_adc_value;
         last_ff <= req_last_of_scan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= '0;
         total_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff   <= phase_code(phase_in);
         active_ff  <= (phase_in != PH_IDLE) && (phase_in != PH_DONE);
         count_ff   <= total_in;
         mode_ff    <= mode;
         rec_ff     <= store_rsp.fire;
         rec_btn_ff <= store_rsp.fire ? btn_ff : '0;
         rest_ff    <= store_rsp.fire ? store_rsp.rest : '0;
         pressed_ff <= store_rsp.fire ? sample : '0;
         min_ff     <= store_rsp.fire ? store_rsp.min : '0;
         max_ff     <= store_rsp.fire ? store_rsp.max : '0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_fsm_state     = state_ff;
   assign rsp_active        = active_ff;
   assign rsp_done_count    = count_ff;
   assign rsp_mode_change   = mode_ff;
   assign rsp_record_valid  = rec_ff;
   assign rsp_record_button = rec_btn_ff;
   assign rsp_rest_value    = rest_ff;
   assign rsp_pressed_value = pressed_ff;
   assign rsp_min_value     = min_ff;
   assign rsp_max_value     = max_ff;

endmodule

FILE: hdl/hbc_checker.sv
// ----------------------------------------------------------------------------
// Hall button calibration checker
// Port-level checks of the calibration sequencer's result channel.
// ----------------------------------------------------------------------------
module hbc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [2:0]                 rsp_fsm_state,
   input logic                       rsp_active,
   input logic [hbc_pkg::CNT_W-1:0]  rsp_done_count,
   input logic [1:0]                 rsp_mode_change,
   input logic                       rsp_record_valid,
   input logic [hbc_pkg::BTN_W-1:0]  rsp_record_button,
   input logic [hbc_pkg::ADC_W-1:0]  rsp_rest_value,
   input logic [hbc_pkg::ADC_W-1:0]  rsp_pressed_value
);
   import hbc_pkg::*;

   // A record is only produced while waiting for presses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_valid |->
         (rsp_fsm_state == STATE_WAIT_PRESS) || (rsp_fsm_state == STATE_CAPTURE_PRESSED))
      else $error("record outside the press phase");

   // The active flag follows the reported phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active ==
         ((rsp_fsm_state != STATE_IDLE) && (rsp_fsm_state != STATE_DONE))))
      else $error("active flag disagrees with phase");

   // Without a record the record fields are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_record_valid |->
         (rsp_record_button == '0) && (rsp_rest_value == '0) && (rsp_pressed_value == '0))
      else $error("record fields not cleared");

   // Enabling calibration mode always reports the release wait.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_change == MODE_ENABLE) |->
         (rsp_fsm_state == STATE_WAIT_RELEASE) && (rsp_done_count == '0))
      else $error("start did not restart calibration");

   // A stalled transfer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_done_count) && $stable(rsp_fsm_state))
      else $error("stalled result changed");

endmodule

bind hall_button_calibration_fsm hbc_checker u_hbc_checker (.*);

FILE: bench/tb_hall_button_calibration_fsm.sv
// ----------------------------------------------------------------------------
// Hall button calibration sequencer testbench
// Drives start, cancel and sample transfers through full calibration runs,
// tracks the sequencer in a scoreboard and checks every response transfer.
// ----------------------------------------------------------------------------
module tb_hall_button_calibration_fsm;
   import hbc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SEGMENTS    = 10;
   localparam int SEG_ITEMS   = 120;

   typedef struct packed {
      logic [2:0]       fsm_state;
      logic             active;
      logic [CNT_W-1:0] done_count;
      logic [1:0]       mode_change;
      logic             record_valid;
      logic [BTN_W-1:0] record_button;
      logic [ADC_W-1:0] rest_value;
      logic [ADC_W-1:0] pressed_value;
      logic [ADC_W-1:0] min_value;
      logic [ADC_W-1:0] max_value;
   } calib_status_type;

   class calibration_tracker_type;
      logic [ADC_W-1:0]  stable_time;
      logic [ADC_W-1:0]  press_delta;
      logic [ADC_W-1:0]  adc_max;
      logic [ADC_W-1:0]  adc_min;
      logic [2:0]        phase;
      logic [TIME_W-1:0] phase_start;
      logic [ADC_W-1:0]  rest[BUTTONS];
      logic [ADC_W-1:0]  low_seen[BUTTONS];
      logic [ADC_W-1:0]  high_seen[BUTTONS];
      bit                calibrated[BUTTONS];
      logic [CNT_W-1:0]  done_total;
      calib_status_type  expected_status[$];
      int                mismatches;

      function new();
         stable_time = STABLE_TIME_RESET;
         press_delta = PRESS_DELTA_RESET;
         adc_max     = ADC_MAX_RESET;
         adc_min     = ADC_MIN_RESET;
         clear_banks();
         phase       = STATE_IDLE;
         phase_start = '0;
         mismatches  = 0;
      endfunction

      function void clear_banks();
         done_total = '0;
         for (int i = 0; i < BUTTONS; i++) begin
            rest[i]       = '0;
            low_seen[i]   = adc_max;
            high_seen[i]  = adc_min;
            calibrated[i] = 1'b0;
         end
      endfunction

      function void apply_register(logic [CSR_W-1:0] index, logic [ADC_W-1:0] data);
         case (index)
            CSR_STABLE_TIME: stable_time = data;
            CSR_PRESS_DELTA: press_delta = data;
            CSR_ADC_MAX:     adc_max     = data;
            CSR_ADC_MIN:     adc_min     = data;
            default: ;
         endcase
      endfunction

      function void enter(logic [2:0] next, logic [TIME_W-1:0] now);
         phase       = next;
         phase_start = now;
      endfunction

      function void note_request(op_type op, logic [TIME_W-1:0] now, logic [BTN_W-1:0] btn,
                                 logic [ADC_W-1:0] adc, logic last);
         calib_status_type s;
         logic [ADC_W-1:0] a;
         logic [ADC_W-1:0] r;
         logic [ADC_W-1:0] d;
         s = '0;
         case (op)
            OP_START: begin
               clear_banks();
               s.mode_change = MODE_ENABLE;
               enter(STATE_WAIT_RELEASE, now);
            end
            OP_CANCEL: begin
               s.mode_change = MODE_DISABLE;
               enter(STATE_IDLE, now);
            end
            OP_SAMPLE: begin
               a = (adc > adc_max) ? adc_max : adc;
               if (int'(btn) < BUTTONS) begin
                  if (phase == STATE_CAPTURE_REST) begin
                     rest[btn]      = a;
                     low_seen[btn]  = a;
                     high_seen[btn] = a;
                  end else if (phase == STATE_WAIT_PRESS) begin
                     r = rest[btn];
                     if (a < low_seen[btn]) low_seen[btn] = a;
                     if (a > high_seen[btn]) high_seen[btn] = a;
                     d = (a > r) ? a - r : r - a;
                     if (!calibrated[btn] && d >= press_delta) begin
                        calibrated[btn] = 1'b1;
                        done_total      = done_total + 1'b1;
                        s.record_valid  = 1'b1;
                        s.record_button = btn;
                        s.rest_value    = r;
                        s.pressed_value = a;
                        s.min_value     = low_seen[btn];
                        s.max_value     = high_seen[btn];
                     end
                  end
               end
               if (last) begin
                  case (phase)
                     STATE_WAIT_RELEASE: begin
                        if (now - phase_start >= TIME_W'(stable_time))
                           enter(STATE_CAPTURE_REST, now);
                     end
                     STATE_CAPTURE_REST: enter(STATE_WAIT_PRESS, now);
                     STATE_WAIT_PRESS: begin
                        if (done_total >= BUTTON_LIMIT) enter(STATE_CAPTURE_PRESSED, now);
                     end
                     STATE_CAPTURE_PRESSED: begin
                        s.mode_change = MODE_DISABLE;
                        enter(STATE_DONE, now);
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         s.fsm_state  = phase;
         s.active     = (phase != STATE_IDLE) && (phase != STATE_DONE);
         s.done_count = done_total;
         expected_status.push_back(s);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got)
            report($sformatf("%s mismatch: expected %0h, actual %0h", name, want, got));
      endfunction

      function void check_response(calib_status_type act);
         calib_status_type e;
         if (expected_status.size() == 0) begin
            report($sformatf("response transfer with nothing outstanding, state %0d",
                             act.fsm_state));
            return;
         end
         e = expected_status.pop_front();
         compare_field("fsm_state", 32'(e.fsm_state), 32'(act.fsm_state));
         compare_field("active", 32'(e.active), 32'(act.active));
         compare_field("done_count", 32'(e.done_count), 32'(act.done_count));
         compare_field("mode_change", 32'(e.mode_change), 32'(act.mode_change));
         compare_field("record_valid", 32'(e.record_valid), 32'(act.record_valid));
         compare_field("record_button", 32'(e.record_button), 32'(act.record_button));
         compare_field("rest_value", 32'(e.rest_value), 32'(act.rest_value));
         compare_field("pressed_value", 32'(e.pressed_value), 32'(act.pressed_value));
         compare_field("min_value", 32'(e.min_value), 32'(act.min_value));
         compare_field("max_value", 32'(e.max_value), 32'(act.max_value));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [1:0]        req_operation    = '0;
   logic [TIME_W-1:0] req_now_ms       = '0;
   logic [BTN_W-1:0]  req_button       = '0;
   logic [ADC_W-1:0]  req_adc_value    = '0;
   logic              req_last_of_scan = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [2:0]        rsp_fsm_state;
   logic              rsp_active;
   logic [CNT_W-1:0]  rsp_done_count;
   logic [1:0]        rsp_mode_change;
   logic              rsp_record_valid;
   logic [BTN_W-1:0]  rsp_record_button;
   logic [ADC_W-1:0]  rsp_rest_value;
   logic [ADC_W-1:0]  rsp_pressed_value;
   logic [ADC_W-1:0]  rsp_min_value;
   logic [ADC_W-1:0]  rsp_max_value;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index        = '0;
   logic [ADC_W-1:0]  csr_data         = '0;

   calib_status_type        observed;
   calibration_tracker_type tracker = new();

   logic [TIME_W-1:0] stamp_ms      = '0;
   int                sent_requests = 0;
   int                gap_pct       = 0;
   int                stall_pct     = 0;
   int                quiet_cycles  = 0;

   hall_button_calibration_fsm dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_now_ms        (req_now_ms),
      .req_button        (req_button),
      .req_adc_value     (req_adc_value),
      .req_last_of_scan  (req_last_of_scan),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fsm_state     (rsp_fsm_state),
      .rsp_active        (rsp_active),
      .rsp_done_count    (rsp_done_count),
      .rsp_mode_change   (rsp_mode_change),
      .rsp_record_valid  (rsp_record_valid),
      .rsp_record_button (rsp_record_button),
      .rsp_rest_value    (rsp_rest_value),
      .rsp_pressed_value (rsp_pressed_value),
      .rsp_min_value     (rsp_min_value),
      .rsp_max_value     (rsp_max_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   assign observed = {rsp_fsm_state, rsp_active, rsp_done_count, rsp_mode_change,
                      rsp_record_valid, rsp_record_button, rsp_rest_value,
                      rsp_pressed_value, rsp_min_value, rsp_max_value};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(observed);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("hall_button_calibration_fsm test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(op_type op, logic [TIME_W-1:0] now, logic [BTN_W-1:0] btn,
                               logic [ADC_W-1:0] adc, logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_now_ms       <= now;
      req_button       <= btn;
      req_adc_value    <= adc;
      req_last_of_scan <= last;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, now, btn, adc, last);
      sent_requests++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic program_registers(int which);
      logic [CSR_W-1:0] regs[4];
      logic [ADC_W-1:0] vals[4];
      regs = '{CSR_STABLE_TIME, CSR_PRESS_DELTA, CSR_ADC_MAX, CSR_ADC_MIN};
      case (which)
         0: vals = '{STABLE_TIME_RESET, PRESS_DELTA_RESET, ADC_MAX_RESET, ADC_MIN_RESET};
         1: vals = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
         2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
         3: vals = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
         default: vals = '{ADC_W'($urandom_range(1000)), ADC_W'($urandom_range(3000, 1)),
                           ADC_W'($urandom_range(65535, 100)), ADC_W'($urandom)};
      endcase
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         tracker.apply_register(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // While waiting for presses, a reading either clears the press threshold or
   // stays inside it; elsewhere the extremes of the range are favored.
   function automatic int pick_reading(int btn, int press_pct);
      int r;
      int dl;
      int m;
      r  = tracker.rest[btn];
      dl = tracker.press_delta;
      m  = tracker.adc_max;
      if (tracker.phase == STATE_WAIT_PRESS && $urandom_range(99) < press_pct) begin
         if (r + dl <= m && (r < dl || $urandom_range(1) == 0))
            return r + dl + (($urandom_range(1) == 0) ? 0 : $urandom_range(m - r - dl));
         if (r >= dl)
            return r - dl - (($urandom_range(1) == 0) ? 0 : $urandom_range(r - dl));
         return ($urandom_range(1) == 0) ? 0 : m;
      end
      if (tracker.phase == STATE_WAIT_PRESS && dl > 0)
         return $urandom_range((r + dl - 1 > m) ? m : r + dl - 1, (r < dl) ? 0 : r - dl + 1);
      case ($urandom_range(3))
         0:       return 0;
         1:       return m;
         default: return $urandom_range(m);
      endcase
   endfunction

   task automatic send_sample(int btn, int target, bit last);
      logic [ADC_W-1:0] raw;
      if ($urandom_range(99) < 6)
         send_request(op_type'($urandom_range(3)), $urandom, BTN_W'($urandom),
                      ADC_W'($urandom), 1'($urandom_range(1)));
      raw = ADC_W'(target);
      if (target >= int'(tracker.adc_max) && $urandom_range(1) == 1)
         raw = ADC_W'($urandom_range(65535, tracker.adc_max));
      send_request(OP_SAMPLE, stamp_ms, BTN_W'(btn), raw, last);
   endtask

   task automatic run_scan(int count, int press_pct);
      int base;
      int btn;
      base     = $urandom_range(BUTTONS - 1);
      stamp_ms = stamp_ms + $urandom_range(40, 1);
      for (int i = 0; i < count; i++) begin
         btn = (base + i) % BUTTONS;
         send_sample(btn, pick_reading(btn, press_pct), i == count - 1);
      end
   endtask

   task automatic run_calibration();
      int scans;
      case ($urandom_range(7))
         0:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(300);
         1:       stamp_ms = $urandom;
         default: ;
      endcase
      send_request(OP_START, stamp_ms, BTN_W'($urandom), ADC_W'($urandom),
                   1'($urandom_range(1)));
      scans = 0;
      while (tracker.phase == STATE_WAIT_RELEASE && scans < 6) begin
         stamp_ms = stamp_ms + (($urandom_range(2) == 0) ? 32'(tracker.stable_time)
                                                         : $urandom_range(tracker.stable_time));
         run_scan($urandom_range(BUTTONS, 1), 0);
         scans++;
      end
      if (tracker.phase == STATE_CAPTURE_REST) run_scan(BUTTONS, 0);
      scans = 0;
      while (tracker.phase == STATE_WAIT_PRESS && scans < 10) begin
         run_scan($urandom_range(BUTTONS, 1), 45);
         scans++;
      end
      if (tracker.phase == STATE_CAPTURE_PRESSED) run_scan($urandom_range(BUTTONS, 1), 0);
      if ($urandom_range(3) == 0) run_scan($urandom_range(3, 1), 0);
      if ($urandom_range(5) == 0)
         send_request(OP_CANCEL, stamp_ms, BTN_W'($urandom), ADC_W'($urandom),
                      1'($urandom_range(1)));
   endtask

   // One complete calibration under the reset register values, with the
   // release timer boundary, clamping, exact press distances and a repeated press.
   task automatic directed_walk();
      logic [ADC_W-1:0] rest_vals[BUTTONS]  = '{16'd0, 16'd4095, 16'hFFFF, 16'd2000,
                                               16'd1000, 16'd3000, 16'd50, 16'd4000};
      logic [ADC_W-1:0] press_vals[BUTTONS] = '{16'd250, 16'd3845, 16'd0, 16'd2250,
                                               16'd1250, 16'd2750, 16'd300, 16'd3750};
      send_request(OP_SAMPLE, 32'd5, 3'd3, 16'hFFFF, 1'b1);
      send_request(OP_RESERVED, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 1'b1);
      stamp_ms = 32'hFFFF_FF80;
      send_request(OP_START, stamp_ms, 3'd0, 16'd0, 1'b0);
      send_request(OP_SAMPLE, stamp_ms + 249, 3'd0, 16'd100, 1'b1);
      send_request(OP_SAMPLE, stamp_ms + 250, 3'd5, 16'd100, 1'b1);
      stamp_ms = stamp_ms + 260;
      for (int b = 0; b < BUTTONS; b++)
         send_request(OP_SAMPLE, stamp_ms, BTN_W'(b), rest_vals[b], b == BUTTONS - 1);
      stamp_ms = stamp_ms + 10;
      send_request(OP_SAMPLE, stamp_ms, 3'd3, 16'd2249, 1'b0);
      for (int b = 0; b < BUTTONS - 1; b++)
         send_request(OP_SAMPLE, stamp_ms, BTN_W'(b), press_vals[b], 1'b0);
      send_request(OP_SAMPLE, stamp_ms, 3'd3, 16'd0, 1'b0);
      send_request(OP_SAMPLE, stamp_ms, 3'd7, press_vals[BUTTONS - 1], 1'b1);
      send_request(OP_SAMPLE, stamp_ms + 10, 3'd1, 16'd0, 1'b1);
      send_request(OP_SAMPLE, stamp_ms + 20, 3'd2, 16'd7, 1'b1);
      send_request(OP_START, stamp_ms + 30, 3'd4, 16'd9, 1'b0);
      send_request(OP_CANCEL, stamp_ms + 40, 3'd6, 16'd11, 1'b1);
   endtask

   initial begin
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_walk();
      stop_sending();
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         while (tracker.expected_status.size() != 0) @(posedge clock);
         program_registers(seg % 5);
         case (seg % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 78; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 78; end
            default: begin gap_pct = 8;  stall_pct = 8;  end
         endcase
         target = sent_requests + SEG_ITEMS;
         while (sent_requests < target) run_calibration();
         stop_sending();
      end
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_status.size() == 0) begin
         $display("hall_button_calibration_fsm test passed");
      end else begin
         $display("hall_button_calibration_fsm test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/hbc_pkg.sv
hdl/hbc_store.sv
hdl/hall_button_calibration_fsm.sv
hdl/hbc_checker.sv
bench/tb_hall_button_calibration_fsm.sv
